FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i and disabled
// while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge out of reset.
`define TBN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that an expression is never true out of reset.
`define TBN_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

FILE: sv/tbn_pkg.sv
// ----------------------------------------------------------------------------
// Tournament barrier node package
// Codes, controller/datapath bundles and the round role helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package tbn_pkg;

  // Input item commands
  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_MSG    = 1'b1;

  // Result item kinds
  localparam logic KIND_SEND    = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // Configuration register indexes
  localparam logic REG_NODE_ID   = 1'b0;
  localparam logic REG_NUM_NODES = 1'b1;

  typedef enum logic [2:0] {
    ROLE_WINNER,
    ROLE_LOSER,
    ROLE_BYE,
    ROLE_CHAMPION,
    ROLE_NONE
  } role_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT_ARRIVAL,
    PH_WAIT_WAKE
  } phase_e;

  typedef enum logic [2:0] {
    WALK_HOLD,
    WALK_ONE,
    WALK_MSG,
    WALK_MSG_DN,
    WALK_INC,
    WALK_DEC
  } walk_op_e;

  // Destination of an emitted item: partner below, partner above, or release
  typedef enum logic [1:0] {
    EM_DOWN,
    EM_UP,
    EM_RELEASE
  } emit_sel_e;

  typedef struct packed {
    logic      capture;
    walk_op_e  walk_op;
    logic      set_arrived;
    logic      clr_arrived;
    logic      set_wake;
    logic      clr_wake;
    logic      park_arrival;
    logic      park_wake;
    logic      emit;
    emit_sel_e emit_sel;
    logic      emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic       item_cmd;
    logic       solo;
    phase_e     phase;
    logic [2:0] cur_round;
    logic       msg_up_ok;
    logic       msg_down_ok;
    logic       msg_round_hit;
    logic       walk_past;
    logic       walk_zero;
    role_e      role;
    logic       arr_hit;
    logic       wake_pending;
    logic       out_free;
    logic       sense;
  } dp_stat_t;

  // Role of a node in a round, given the effective node count
  function automatic role_e role_of(input logic [5:0] node, input logic [2:0] rnd,
                                    input logic [6:0] p);
    logic [7:0] m;
    logic [7:0] h;
    logic [7:0] rem;
    logic [7:0] sum;
    logic [7:0] pp;
    role_e      role;
    m    = 8'd1 << rnd;
    h    = 8'd1 << (rnd - 3'd1);
    rem  = {2'b00, node} & (m - 8'd1);
    sum  = {2'b00, node} + h;
    pp   = {1'b0, p};
    if (rem == 8'd0 && sum < pp && m < pp) begin
      role = ROLE_WINNER;
    end else if (rem == 8'd0 && sum >= pp) begin
      role = ROLE_BYE;
    end else if (rem == h) begin
      role = ROLE_LOSER;
    end else if (node == 6'd0 && m >= pp) begin
      role = ROLE_CHAMPION;
    end else begin
      role = ROLE_NONE;
    end
    return role;
  endfunction

  // Number of rounds: smallest r with 2^r >= p
  function automatic logic [2:0] round_count(input logic [6:0] p);
    logic [2:0] r;
    r = 3'd6;
    for (int k = 6; k >= 0; k--) begin
      if ((8'd1 << k) >= {1'b0, p}) begin
        r = 3'(k);
      end
    end
    return r;
  endfunction

  // Round whose half distance equals d, zero if none within r rounds
  function automatic logic [2:0] round_for(input logic [5:0] d, input logic [2:0] r);
    logic [2:0] j;
    j = 3'd0;
    for (int k = 1; k <= 6; k++) begin
      if (3'(k) <= r && d == 6'(32'd1 << (k - 1))) begin
        j = 3'(k);
      end
    end
    return j;
  endfunction

endpackage

`default_nettype wire

FILE: sv/tbn_in_if.sv
// ----------------------------------------------------------------------------
// Tournament barrier node input channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
`default_nettype none

interface tbn_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [5:0] src_node;

  modport source (output valid, output cmd, output src_node, input ready);
  modport sink   (input valid, input cmd, input src_node, output ready);
endinterface

`default_nettype wire

FILE: sv/tbn_out_if.sv
// ----------------------------------------------------------------------------
// Tournament barrier node output channel
// Valid/ready channel carrying one message or release item.
// ----------------------------------------------------------------------------
`default_nettype none

interface tbn_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [5:0] dest_node;
  logic       msg_sense;
  logic       last;

  modport source (output valid, output kind, output dest_node, output msg_sense,
                  output last, input ready);
  modport sink   (input valid, input kind, input dest_node, input msg_sense,
                  input last, output ready);
endinterface

`default_nettype wire

FILE: sv/tbn_cfg.sv
// ----------------------------------------------------------------------------
// Tournament barrier node configuration registers
// APB-style register file holding the node id and the node count.
// ----------------------------------------------------------------------------
`default_nettype none

module tbn_cfg (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [5:0]       node_id_o,
  output logic [6:0]       num_nodes_o
);

  logic [5:0] node_id_q;
  logic [6:0] num_nodes_q;
  logic       wr_en;
  logic       reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel & penable & pwrite;

  // Write on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q   <= 6'd0;
      num_nodes_q <= 7'd1;
    end else if (wr_en) begin
      unique case (reg_idx)
        tbn_pkg::REG_NODE_ID:   node_id_q   <= pwdata[5:0];
        tbn_pkg::REG_NUM_NODES: num_nodes_q <= pwdata[6:0];
        default:                node_id_q   <= node_id_q;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (reg_idx)
      tbn_pkg::REG_NODE_ID:   prdata = {26'd0, node_id_q};
      tbn_pkg::REG_NUM_NODES: prdata = {25'd0, num_nodes_q};
      default:                prdata = 32'd0;
    endcase
  end

  assign node_id_o   = node_id_q;
  assign num_nodes_o = num_nodes_q;

endmodule

`default_nettype wire

FILE: sv/tbn_dp.sv
// ----------------------------------------------------------------------------
// Tournament barrier node datapath
// Holds barrier state, the round walk counter, the captured item and the
// output register; reports roles and message checks to the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module tbn_dp #(
  parameter int MAX_NODES = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [5:0]       node_id_i,
  input  wire logic [6:0]       num_nodes_i,
  input  wire logic             in_cmd_i,
  input  wire logic [5:0]       in_src_node_i,
  input  wire tbn_pkg::dp_cmd_t cmd_i,
  output tbn_pkg::dp_stat_t     stat_o,
  input  wire logic             out_ready_i,
  output logic                  out_valid_o,
  output logic                  out_kind_o,
  output logic [5:0]            out_dest_node_o,
  output logic                  out_msg_sense_o,
  output logic                  out_last_o
);

  localparam logic [6:0] NodeCap = 7'((MAX_NODES < 64) ? MAX_NODES : 64);

  // Barrier state
  logic            sense_q,    sense_d;
  logic [2:0]      cur_q,      cur_d;
  tbn_pkg::phase_e phase_q,    phase_d;
  logic [6:0]      arrived_q,  arrived_d;
  logic            wake_q,     wake_d;
  logic [2:0]      walk_q,     walk_d;

  // Captured item
  logic       item_cmd_q;
  logic [5:0] item_src_q;

  // Output register
  logic       out_valid_q;
  logic       out_kind_q;
  logic [5:0] out_dest_q;
  logic       out_sense_q;
  logic       out_last_q;

  logic [6:0]     p_eff;
  logic [2:0]     rounds;
  logic           solo;
  logic           msg_up;
  logic [5:0]     msg_dist;
  logic [2:0]     msg_j;
  tbn_pkg::role_e msg_role;
  tbn_pkg::role_e walk_role;
  logic [7:0]     walk_bit;
  logic [7:0]     msg_bit;
  logic [7:0]     arr_ext;
  logic [6:0]     h_walk;
  logic [5:0]     dest_up;
  logic [5:0]     dest_down;
  logic           out_free;
  logic           do_release;

  // Effective node count, round count and solo case
  always_comb begin
    p_eff = (num_nodes_i == 7'd0) ? 7'd1 : num_nodes_i;
    if (p_eff > NodeCap) begin
      p_eff = NodeCap;
    end
  end
  assign rounds = tbn_pkg::round_count(p_eff);
  assign solo   = (p_eff <= 7'd1) || ({1'b0, node_id_i} >= p_eff);

  // Decode the captured message against this node's rounds
  assign msg_up   = item_src_q > node_id_i;
  assign msg_dist = msg_up ? (item_src_q - node_id_i) : (node_id_i - item_src_q);
  assign msg_j    = tbn_pkg::round_for(msg_dist, rounds);
  assign msg_role = tbn_pkg::role_of(node_id_i, msg_j, p_eff);

  // Role and partner offsets of the walked round
  assign walk_role = tbn_pkg::role_of(node_id_i, walk_q, p_eff);
  assign walk_bit  = 8'd1 << walk_q;
  assign msg_bit   = 8'd1 << msg_j;
  assign arr_ext   = {1'b0, arrived_q};
  assign h_walk    = 7'd1 << (walk_q - 3'd1);
  assign dest_up   = node_id_i + h_walk[5:0];
  assign dest_down = node_id_i - h_walk[5:0];

  assign out_free   = !out_valid_q || out_ready_i;
  assign do_release = cmd_i.emit && (cmd_i.emit_sel == tbn_pkg::EM_RELEASE);

  // Status to the controller
  always_comb begin
    stat_o.item_cmd      = item_cmd_q;
    stat_o.solo          = solo;
    stat_o.phase         = phase_q;
    stat_o.cur_round     = cur_q;
    stat_o.msg_up_ok     = !solo && msg_up && (msg_j != 3'd0) &&
                           (msg_role == tbn_pkg::ROLE_WINNER ||
                            msg_role == tbn_pkg::ROLE_CHAMPION);
    stat_o.msg_down_ok   = !solo && (item_src_q < node_id_i) && (msg_j != 3'd0) &&
                           (msg_role == tbn_pkg::ROLE_LOSER);
    stat_o.msg_round_hit = (cur_q == msg_j);
    stat_o.walk_past     = walk_q > rounds;
    stat_o.walk_zero     = (walk_q == 3'd0);
    stat_o.role          = walk_role;
    stat_o.arr_hit       = arr_ext[walk_q];
    stat_o.wake_pending  = wake_q;
    stat_o.out_free      = out_free;
    stat_o.sense         = sense_q;
  end

  // Next barrier state
  always_comb begin
    sense_d   = sense_q;
    cur_d     = cur_q;
    phase_d   = phase_q;
    arrived_d = arrived_q;
    wake_d    = wake_q;
    walk_d    = walk_q;

    if (cmd_i.set_arrived) begin
      arrived_d = arrived_d | msg_bit[6:0];
    end
    if (cmd_i.clr_arrived) begin
      arrived_d = arrived_d & ~walk_bit[6:0];
    end
    if (cmd_i.set_wake) begin
      wake_d = 1'b1;
    end
    if (cmd_i.clr_wake) begin
      wake_d = 1'b0;
    end
    if (cmd_i.park_arrival) begin
      phase_d = tbn_pkg::PH_WAIT_ARRIVAL;
      cur_d   = walk_q;
    end
    if (cmd_i.park_wake) begin
      phase_d = tbn_pkg::PH_WAIT_WAKE;
      cur_d   = walk_q;
    end
    if (do_release) begin
      sense_d = ~sense_q;
      phase_d = tbn_pkg::PH_IDLE;
      cur_d   = 3'd0;
    end

    unique case (cmd_i.walk_op)
      tbn_pkg::WALK_HOLD:   walk_d = walk_q;
      tbn_pkg::WALK_ONE:    walk_d = 3'd1;
      tbn_pkg::WALK_MSG:    walk_d = msg_j;
      tbn_pkg::WALK_MSG_DN: walk_d = msg_j - 3'd1;
      tbn_pkg::WALK_INC:    walk_d = walk_q + 3'd1;
      tbn_pkg::WALK_DEC:    walk_d = walk_q - 3'd1;
      default:              walk_d = walk_q;
    endcase
  end

  // Hold barrier state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sense_q   <= 1'b1;
      cur_q     <= 3'd0;
      phase_q   <= tbn_pkg::PH_IDLE;
      arrived_q <= 7'd0;
      wake_q    <= 1'b0;
      walk_q    <= 3'd0;
    end else begin
      sense_q   <= sense_d;
      cur_q     <= cur_d;
      phase_q   <= phase_d;
      arrived_q <= arrived_d;
      wake_q    <= wake_d;
      walk_q    <= walk_d;
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_cmd_q <= in_cmd_i;
      item_src_q <= in_src_node_i;
    end
  end

  // Output valid: set on emit, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_sense_q <= sense_q;
      out_last_q  <= cmd_i.emit_last;
      unique case (cmd_i.emit_sel)
        tbn_pkg::EM_DOWN: begin
          out_kind_q <= tbn_pkg::KIND_SEND;
          out_dest_q <= dest_down;
        end
        tbn_pkg::EM_UP: begin
          out_kind_q <= tbn_pkg::KIND_SEND;
          out_dest_q <= dest_up;
        end
        default: begin
          out_kind_q <= tbn_pkg::KIND_RELEASE;
          out_dest_q <= 6'd0;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_kind_o      = out_kind_q;
  assign out_dest_node_o = out_dest_q;
  assign out_msg_sense_o = out_sense_q;
  assign out_last_o      = out_last_q;

endmodule

`default_nettype wire

FILE: sv/tbn_ctrl.sv
// ----------------------------------------------------------------------------
// Tournament barrier node controller
// Sequences decode, the climb up the rounds, the descent and the release.
// ----------------------------------------------------------------------------
`default_nettype none

module tbn_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire tbn_pkg::dp_stat_t stat_i,
  output tbn_pkg::dp_cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CLIMB,
    ST_DESCEND,
    ST_RELEASE
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_d            = state_q;
    cmd_o              = '0;
    cmd_o.walk_op      = tbn_pkg::WALK_HOLD;
    cmd_o.emit_sel     = tbn_pkg::EM_RELEASE;

    unique case (state_q)
      ST_IDLE: begin
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_DECODE;
        end
      end

      ST_DECODE: begin
        if (stat_i.item_cmd == tbn_pkg::CMD_ARRIVE) begin
          if (stat_i.phase != tbn_pkg::PH_IDLE) begin
            state_d = ST_IDLE;
          end else if (stat_i.solo) begin
            state_d = ST_RELEASE;
          end else begin
            cmd_o.walk_op = tbn_pkg::WALK_ONE;
            state_d       = ST_CLIMB;
          end
        end else if (stat_i.msg_up_ok) begin
          // Buffer the arrival; resume the climb if parked on that round
          cmd_o.set_arrived = 1'b1;
          if (stat_i.phase == tbn_pkg::PH_WAIT_ARRIVAL && stat_i.msg_round_hit) begin
            cmd_o.walk_op = tbn_pkg::WALK_MSG;
            state_d       = ST_CLIMB;
          end else begin
            state_d = ST_IDLE;
          end
        end else if (stat_i.msg_down_ok) begin
          // Wake-up: descend if parked on that round, else remember it
          if (stat_i.phase == tbn_pkg::PH_WAIT_WAKE && stat_i.msg_round_hit) begin
            cmd_o.walk_op = tbn_pkg::WALK_MSG_DN;
            state_d       = ST_DESCEND;
          end else begin
            cmd_o.set_wake = 1'b1;
            state_d        = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end

      ST_CLIMB: begin
        if (stat_i.walk_past) begin
          state_d = ST_RELEASE;
        end else begin
          unique case (stat_i.role)
            tbn_pkg::ROLE_WINNER: begin
              if (stat_i.arr_hit) begin
                cmd_o.clr_arrived = 1'b1;
                cmd_o.walk_op     = tbn_pkg::WALK_INC;
              end else begin
                cmd_o.park_arrival = 1'b1;
                state_d            = ST_IDLE;
              end
            end
            tbn_pkg::ROLE_LOSER: begin
              if (stat_i.out_free) begin
                cmd_o.emit      = 1'b1;
                cmd_o.emit_sel  = tbn_pkg::EM_DOWN;
                cmd_o.emit_last = !stat_i.wake_pending;
                if (stat_i.wake_pending) begin
                  cmd_o.clr_wake = 1'b1;
                  cmd_o.walk_op  = tbn_pkg::WALK_DEC;
                  state_d        = ST_DESCEND;
                end else begin
                  cmd_o.park_wake = 1'b1;
                  state_d         = ST_IDLE;
                end
              end
            end
            tbn_pkg::ROLE_CHAMPION: begin
              if (!stat_i.arr_hit) begin
                cmd_o.park_arrival = 1'b1;
                state_d            = ST_IDLE;
              end else if (stat_i.out_free) begin
                cmd_o.clr_arrived = 1'b1;
                cmd_o.emit        = 1'b1;
                cmd_o.emit_sel    = tbn_pkg::EM_UP;
                cmd_o.walk_op     = tbn_pkg::WALK_DEC;
                state_d           = ST_DESCEND;
              end
            end
            default: begin
              // Bye or no role: advance to the next round
              cmd_o.walk_op = tbn_pkg::WALK_INC;
            end
          endcase
        end
      end

      ST_DESCEND: begin
        if (stat_i.walk_zero) begin
          state_d = ST_RELEASE;
        end else if (stat_i.role == tbn_pkg::ROLE_WINNER) begin
          if (stat_i.out_free) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_sel = tbn_pkg::EM_UP;
            cmd_o.walk_op  = tbn_pkg::WALK_DEC;
          end
        end else begin
          cmd_o.walk_op = tbn_pkg::WALK_DEC;
        end
      end

      ST_RELEASE: begin
        if (stat_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_sel  = tbn_pkg::EM_RELEASE;
          cmd_o.emit_last = 1'b1;
          state_d         = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/tournament_barrier_node.sv
// Sequence: an item is decoded in the cycle after it is accepted, then the walk
//   climbs or descends the rounds and ends with the release; output
//   back-pressure stalls the walk while the output register is full.
// Throughput: one item at a time; ready is held low until the round walk of
//   the previous item is done. Results leave through a one-deep output register.
// Reset: rst_ni is asynchronous, active low; sense returns to one, the node
//   to idle with no buffered arrivals or wake-up, node_id to 0, num_nodes to 1.
// ----------------------------------------------------------------------------
// Tournament barrier node
// One node's controller for a tournament barrier: climbs the rounds on a
// local arrival, exchanges arrival and wake-up messages, then releases.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tournament_barrier_node #(
  parameter int MAX_NODES = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  tbn_in_if.sink           in_i,
  tbn_out_if.source        out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [5:0]        node_id;
  logic [6:0]        num_nodes;
  tbn_pkg::dp_cmd_t  cmd;
  tbn_pkg::dp_stat_t stat;
  logic              in_ready;
  logic              release_emit;

  // Configuration registers
  tbn_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .node_id_o   (node_id),
    .num_nodes_o (num_nodes)
  );

  // Sequencer
  tbn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  assign in_i.ready = in_ready;

  // Barrier state and output register
  tbn_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .node_id_i       (node_id),
    .num_nodes_i     (num_nodes),
    .in_cmd_i        (in_i.cmd),
    .in_src_node_i   (in_i.src_node),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .out_kind_o      (out_o.kind),
    .out_dest_node_o (out_o.dest_node),
    .out_msg_sense_o (out_o.msg_sense),
    .out_last_o      (out_o.last)
  );

  assign release_emit = cmd.emit && (cmd.emit_sel == tbn_pkg::EM_RELEASE);

  // A new item is never taken while the previous one is decoded
  `TBN_ASSERT(a_no_accept_in_decode, in_i.valid && in_i.ready |=> !in_i.ready, "accept in decode")
  // A waiting node always knows its round
  `TBN_ASSERT(a_wait_round, stat.phase != tbn_pkg::PH_IDLE |-> stat.cur_round != 3'd0, "no round")
  // Never overwrite a result that is still waiting
  `TBN_ASSERT_NEVER(a_emit_overrun, cmd.emit && !stat.out_free, "emit while output register full")
  // A release flips the sense
  `TBN_ASSERT(a_release_flips, release_emit |=> stat.sense != $past(stat.sense), "sense kept")

endmodule

`default_nettype wire
